### design/cmb_pkg.sv
// Shared constants, operation and result codes for the client memory budget table.
`default_nettype none
package cmb_pkg;

  // Table geometry.
  localparam int MaxTabs    = 16;
  localparam int MaxResults = 16;
  localparam int SlotW      = $clog2(MaxTabs);
  localparam int CntW       = ($clog2(MaxTabs + 1) > 5) ? $clog2(MaxTabs + 1) : 5;
  localparam int SentW      = $clog2(MaxResults + 1);

  // Field widths.
  localparam int IdW    = 48;
  localparam int BytesW = 48;
  localparam int SumW   = 52;
  localparam int FracW  = 17;
  localparam int MibW   = 18;
  localparam int QuoW   = 49;
  localparam int PaddrW = 6;
  localparam int PdataW = 64;

  localparam logic [FracW-1:0] FracOne = FracW'(65536);

  // Operation codes.
  typedef enum logic [2:0] {
    OP_REGISTER   = 3'd0,
    OP_UNREGISTER = 3'd1,
    OP_SETCLASS   = 3'd2,
    OP_REPORT     = 3'd3,
    OP_QUERY      = 3'd4,
    OP_PRESSURE   = 3'd5,
    OP_EVICT      = 3'd6,
    OP_NONE       = 3'd7
  } op_e;

  // Result codes.
  typedef enum logic [2:0] {
    CODE_OK       = 3'd0,
    CODE_NOTFOUND = 3'd1,
    CODE_FULL     = 3'd2,
    CODE_NOVICTIM = 3'd3,
    CODE_GC       = 3'd4,
    CODE_SUSPEND  = 3'd5,
    CODE_EVICTED  = 3'd6
  } code_e;

  // Priority classes.
  typedef enum logic [1:0] {
    CLS_ACTIVE     = 2'd0,
    CLS_MEDIA      = 2'd1,
    CLS_BACKGROUND = 2'd2,
    CLS_SUSPENDED  = 2'd3
  } cls_e;

  // Register indexes.
  localparam logic [2:0] RegAvail     = 3'd0;
  localparam logic [2:0] RegFracAct   = 3'd1;
  localparam logic [2:0] RegFracMedia = 3'd2;
  localparam logic [2:0] RegFracBg    = 3'd3;
  localparam logic [2:0] RegFracSusp  = 3'd4;
  localparam logic [2:0] RegMinMib    = 3'd5;
  localparam logic [2:0] RegMaxMib    = 3'd6;

  // Pressure thresholds.
  localparam logic [7:0] LvlModerate = 8'd2;
  localparam logic [7:0] LvlCritical = 8'd3;

endpackage
`default_nettype wire

### design/class_memory_budget_table.sv
// Client memory budget table: slot scans, shared multiply and divide sequencer, APB registers.
// Lookup walks up to 16 slots, one per cycle; a budget recompute makes a count pass over all
// 16 slots, then per populated class two multiply steps, 49 divide steps and one clamp.
// Register, unregister and set class run a lookup and a recompute, evict a ranking walk and a
// recompute; report and query a lookup only; pressure a scan and recompute, then one result per set slot.
// One transaction is worked at a time; the result register lets the next one enter meanwhile.
// Reset clears all valid bits, counts, budgets and the usage sum at once; no clearing pass.
`default_nettype none
module class_memory_budget_table import cmb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [2:0]        op_i,
  input  wire logic [IdW-1:0]    client_id_i,
  input  wire logic [1:0]        class_in_i,
  input  wire logic [BytesW-1:0] used_in_i,
  input  wire logic [7:0]        pressure_level_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [IdW-1:0]         client_out_o,
  output logic [2:0]             code_o,
  output logic [1:0]             class_out_o,
  output logic [BytesW-1:0]      budget_out_o,
  output logic [BytesW-1:0]      used_out_o,
  output logic [BytesW-1:0]      peak_out_o,
  output logic [4:0]             active_count_o,
  output logic [4:0]             media_count_o,
  output logic [4:0]             background_count_o,
  output logic [4:0]             suspended_count_o,
  output logic [SumW-1:0]        total_used_o,
  output logic                   last_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0]      prdata,
  output logic                   pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_EXEC, S_PSCAN, S_ESCAN, S_EVICT, S_CNT,
    S_MULLO, S_MULHI, S_DIV, S_CLAMP, S_EFIND, S_SEND
  } state_e;

  typedef enum logic [1:0] {SEL_ZERO, SEL_ENTRY, SEL_CAPT} sel_e;

  state_e state_q;
  sel_e   sel_q;
  code_e  code_q;

  // Configuration registers.
  logic [BytesW-1:0] avail_q;
  logic [FracW-1:0]  frac_q [4];
  logic [MibW-1:0]   min_q, max_q;

  // Table state.
  logic [MaxTabs-1:0] valid_q;
  logic [IdW-1:0]     ent_id_q   [MaxTabs];
  logic [1:0]         ent_cls_q  [MaxTabs];
  logic [BytesW-1:0]  ent_used_q [MaxTabs];
  logic [BytesW-1:0]  ent_peak_q [MaxTabs];
  logic [CntW-1:0]    cnt_q [4];
  logic [BytesW-1:0]  bud_q [4];
  logic [SumW-1:0]    sum_q;

  // Latched transaction.
  op_e               op_q;
  logic [IdW-1:0]    cmd_id_q;
  logic [1:0]        cmd_cls_q;
  logic [BytesW-1:0] cmd_used_q;
  logic [7:0]        lvl_q;

  // Sequencer working registers.
  logic [SlotW-1:0]   ptr_q, hit_q;
  logic               found_q, free_ok_q, any_q;
  logic [1:0]         bc_q, ci_q;
  logic [BytesW-1:0]  bu_q;
  logic [MaxTabs-1:0] mask_q;
  logic [SentW-1:0]   sent_q;
  logic [40:0]        acc_q;
  logic [QuoW-1:0]    quo_q;
  logic [CntW-1:0]    rem_q;
  logic [5:0]         bit_q;
  logic [IdW-1:0]     zid_q, cap_id_q;
  logic [1:0]         cap_cls_q;
  logic [BytesW-1:0]  cap_bud_q, cap_used_q, cap_peak_q;

  // Single table read port.
  logic              use_ptr;
  logic [SlotW-1:0]  rd_idx;
  logic              rd_valid;
  logic [IdW-1:0]    rd_id;
  logic [1:0]        rd_cls;
  logic [BytesW-1:0] rd_used, rd_peak, rd_bud;
  logic              last_ptr;

  assign use_ptr = (state_q == S_LOOK) || (state_q == S_PSCAN) || (state_q == S_ESCAN) ||
                   (state_q == S_CNT) || (state_q == S_EFIND) ||
                   ((state_q == S_SEND) && (op_q == OP_PRESSURE));
  assign rd_idx   = use_ptr ? ptr_q : hit_q;
  assign rd_valid = valid_q[rd_idx];
  assign rd_id    = ent_id_q[rd_idx];
  assign rd_cls   = ent_cls_q[rd_idx];
  assign rd_used  = ent_used_q[rd_idx];
  assign rd_peak  = ent_peak_q[rd_idx];
  assign rd_bud   = bud_q[rd_cls];
  assign last_ptr = (ptr_q == SlotW'(MaxTabs - 1));

  // Shared multiplier: one 24-bit half of the available bytes times the saturated fraction.
  logic [FracW-1:0] frac_sat;
  logic [23:0]      mul_a;
  logic [40:0]      mul_p;
  logic [64:0]      mul_sum;
  assign frac_sat = (frac_q[ci_q] > FracOne) ? FracOne : frac_q[ci_q];
  assign mul_a    = (state_q == S_MULHI) ? avail_q[47:24] : avail_q[23:0];
  assign mul_p    = 41'(mul_a) * 41'(frac_sat);
  assign mul_sum  = {mul_p, 24'b0} + 65'(acc_q);

  // Restoring divide step by the class count.
  logic [CntW:0]   rem_s;
  logic            div_ge;
  logic [CntW:0]   rem_sub;
  assign rem_s   = {rem_q, quo_q[QuoW-1]};
  assign div_ge  = rem_s >= {1'b0, cnt_q[ci_q]};
  assign rem_sub = rem_s - {1'b0, cnt_q[ci_q]};

  // Clamp to the MiB window, maximum last.
  logic [QuoW-1:0] lo_b, hi_b, clamp_lo, clamp_b;
  assign lo_b     = QuoW'({min_q, 20'b0});
  assign hi_b     = QuoW'({max_q, 20'b0});
  assign clamp_lo = (quo_q < lo_b) ? lo_b : quo_q;
  assign clamp_b  = (clamp_lo > hi_b) ? hi_b : clamp_lo;

  // Pressure request and eviction ranking for the slot under the pointer.
  logic pres_req, evict_better, rest_empty, send_last, pres_send;
  code_e pres_code;
  assign pres_req = rd_valid &&
                    ((lvl_q >= LvlCritical) ?
                       ((rd_cls == CLS_BACKGROUND) || (rd_cls == CLS_ACTIVE)) :
                     (lvl_q >= LvlModerate) ? (rd_used > rd_bud) : 1'b0);
  assign evict_better = rd_valid && (rd_cls != CLS_MEDIA) &&
                        (!any_q || (rd_cls > bc_q) || ((rd_cls == bc_q) && (rd_used > bu_q)));
  assign pres_code  = ((lvl_q >= LvlCritical) && (rd_cls == CLS_BACKGROUND)) ?
                      CODE_SUSPEND : CODE_GC;
  assign rest_empty = ((mask_q & ~(MaxTabs'(1) << ptr_q)) == '0);
  assign pres_send  = (op_q == OP_PRESSURE) && (sel_q == SEL_ENTRY);
  assign send_last  = !pres_send || rest_empty || (sent_q == SentW'(MaxResults - 1));

  logic out_free;
  assign out_free = !out_valid_o || out_ready_i;

  assign in_ready_o = (state_q == S_IDLE);
  assign pready     = 1'b1;

  // Register read-back.
  always_comb begin
    case (paddr[5:3])
      RegAvail:     prdata = PdataW'(avail_q);
      RegFracAct:   prdata = PdataW'(frac_q[0]);
      RegFracMedia: prdata = PdataW'(frac_q[1]);
      RegFracBg:    prdata = PdataW'(frac_q[2]);
      RegFracSusp:  prdata = PdataW'(frac_q[3]);
      RegMinMib:    prdata = PdataW'(min_q);
      RegMaxMib:    prdata = PdataW'(max_q);
      default:      prdata = '0;
    endcase
  end

  // Entry payload writes; all go through the hit slot.
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      case (op_q)
        OP_REGISTER: begin
          if (found_q || free_ok_q) begin
            ent_id_q[hit_q]   <= cmd_id_q;
            ent_cls_q[hit_q]  <= cmd_cls_q;
            ent_used_q[hit_q] <= '0;
            ent_peak_q[hit_q] <= '0;
          end
        end
        OP_SETCLASS: begin
          if (found_q) ent_cls_q[hit_q] <= cmd_cls_q;
        end
        OP_REPORT: begin
          if (found_q) begin
            ent_used_q[hit_q] <= cmd_used_q;
            if (cmd_used_q > rd_peak) ent_peak_q[hit_q] <= cmd_used_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Sequencer, configuration, table control and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      sel_q      <= SEL_ZERO;
      code_q     <= CODE_OK;
      avail_q    <= BytesW'(64'd3758096384);
      frac_q[0]  <= FracW'(39322);
      frac_q[1]  <= FracW'(16384);
      frac_q[2]  <= FracW'(6554);
      frac_q[3]  <= FracW'(3277);
      min_q      <= MibW'(32);
      max_q      <= MibW'(512);
      valid_q    <= '0;
      for (int c = 0; c < 4; c++) begin
        cnt_q[c] <= '0;
        bud_q[c] <= '0;
      end
      sum_q      <= '0;
      op_q       <= OP_NONE;
      cmd_id_q   <= '0;
      cmd_cls_q  <= '0;
      cmd_used_q <= '0;
      lvl_q      <= '0;
      ptr_q      <= '0;
      hit_q      <= '0;
      found_q    <= 1'b0;
      free_ok_q  <= 1'b0;
      any_q      <= 1'b0;
      bc_q       <= '0;
      ci_q       <= '0;
      bu_q       <= '0;
      mask_q     <= '0;
      sent_q     <= '0;
      acc_q      <= '0;
      quo_q      <= '0;
      rem_q      <= '0;
      bit_q      <= '0;
      zid_q      <= '0;
      cap_id_q   <= '0;
      cap_cls_q  <= '0;
      cap_bud_q  <= '0;
      cap_used_q <= '0;
      cap_peak_q <= '0;
      out_valid_o        <= 1'b0;
      client_out_o       <= '0;
      code_o             <= '0;
      class_out_o        <= '0;
      budget_out_o       <= '0;
      used_out_o         <= '0;
      peak_out_o         <= '0;
      active_count_o     <= '0;
      media_count_o      <= '0;
      background_count_o <= '0;
      suspended_count_o  <= '0;
      total_used_o       <= '0;
      last_o             <= 1'b0;
    end else begin
      // Configuration writes.
      if (psel && penable && pwrite) begin
        case (paddr[5:3])
          RegAvail:     avail_q   <= pwdata[BytesW-1:0];
          RegFracAct:   frac_q[0] <= pwdata[FracW-1:0];
          RegFracMedia: frac_q[1] <= pwdata[FracW-1:0];
          RegFracBg:    frac_q[2] <= pwdata[FracW-1:0];
          RegFracSusp:  frac_q[3] <= pwdata[FracW-1:0];
          RegMinMib:    min_q     <= pwdata[MibW-1:0];
          RegMaxMib:    max_q     <= pwdata[MibW-1:0];
          default: ;
        endcase
      end

      // The result register empties when the consumer takes it and nothing new is loaded.
      if (out_valid_o && out_ready_i && (state_q != S_SEND)) out_valid_o <= 1'b0;

      case (state_q)
        // Take a transaction and pick its first walk.
        S_IDLE: begin
          if (in_valid_i) begin
            op_q       <= op_e'(op_i);
            cmd_id_q   <= client_id_i;
            cmd_cls_q  <= class_in_i;
            cmd_used_q <= used_in_i;
            lvl_q      <= pressure_level_i;
            found_q    <= 1'b0;
            free_ok_q  <= 1'b0;
            any_q      <= 1'b0;
            mask_q     <= '0;
            ptr_q      <= '0;
            case (op_e'(op_i))
              OP_PRESSURE: state_q <= S_PSCAN;
              OP_EVICT:    state_q <= S_ESCAN;
              OP_NONE:     state_q <= S_IDLE;
              default:     state_q <= S_LOOK;
            endcase
          end
        end

        // Look up the id; remember the lowest free slot on the way.
        S_LOOK: begin
          if (rd_valid && (rd_id == cmd_id_q)) begin
            found_q <= 1'b1;
            hit_q   <= ptr_q;
            state_q <= S_EXEC;
          end else begin
            if (!rd_valid && !free_ok_q) begin
              free_ok_q <= 1'b1;
              hit_q     <= ptr_q;
            end
            if (last_ptr) state_q <= S_EXEC;
            else ptr_q <= ptr_q + 1'b1;
          end
        end

        // Apply a single-entry operation.
        S_EXEC: begin
          ptr_q <= '0;
          zid_q <= cmd_id_q;
          if (!found_q && (op_q != OP_REGISTER)) begin
            code_q  <= CODE_NOTFOUND;
            sel_q   <= SEL_ZERO;
            state_q <= S_SEND;
          end else begin
            case (op_q)
              OP_REGISTER: begin
                if (!found_q && !free_ok_q) begin
                  code_q  <= CODE_FULL;
                  sel_q   <= SEL_ZERO;
                  state_q <= S_SEND;
                end else begin
                  code_q         <= CODE_OK;
                  sel_q          <= SEL_ENTRY;
                  valid_q[hit_q] <= 1'b1;
                  if (found_q) sum_q <= sum_q - SumW'(rd_used);
                  for (int c = 0; c < 4; c++) cnt_q[c] <= '0;
                  state_q <= S_CNT;
                end
              end
              OP_UNREGISTER: begin
                code_q         <= CODE_OK;
                cap_id_q       <= cmd_id_q;
                cap_cls_q      <= rd_cls;
                cap_bud_q      <= rd_bud;
                cap_used_q     <= rd_used;
                cap_peak_q     <= rd_peak;
                valid_q[hit_q] <= 1'b0;
                sum_q          <= sum_q - SumW'(rd_used);
                for (int c = 0; c < 4; c++) cnt_q[c] <= '0;
                sel_q          <= SEL_CAPT;
                state_q        <= S_CNT;
              end
              OP_SETCLASS: begin
                code_q  <= CODE_OK;
                sel_q   <= SEL_ENTRY;
                for (int c = 0; c < 4; c++) cnt_q[c] <= '0;
                state_q <= S_CNT;
              end
              OP_REPORT: begin
                code_q  <= CODE_OK;
                sel_q   <= SEL_ENTRY;
                sum_q   <= sum_q - SumW'(rd_used) + SumW'(cmd_used_q);
                state_q <= S_SEND;
              end
              OP_QUERY: begin
                code_q  <= CODE_OK;
                sel_q   <= SEL_ENTRY;
                state_q <= S_SEND;
              end
              default:  state_q <= S_IDLE;
            endcase
          end
        end

        // Mark pressure requests against the budgets as they stand.
        S_PSCAN: begin
          mask_q[ptr_q] <= pres_req;
          if (last_ptr) begin
            ptr_q <= '0;
            for (int c = 0; c < 4; c++) cnt_q[c] <= '0;
            state_q <= S_CNT;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end

        // Rank eviction candidates.
        S_ESCAN: begin
          if (evict_better) begin
            any_q <= 1'b1;
            hit_q <= ptr_q;
            bc_q  <= rd_cls;
            bu_q  <= rd_used;
          end
          if (last_ptr) state_q <= S_EVICT;
          else ptr_q <= ptr_q + 1'b1;
        end

        // Remove the chosen victim.
        S_EVICT: begin
          ptr_q <= '0;
          zid_q <= '0;
          if (!any_q) begin
            code_q  <= CODE_NOVICTIM;
            sel_q   <= SEL_ZERO;
            state_q <= S_SEND;
          end else begin
            cap_id_q       <= rd_id;
            cap_cls_q      <= rd_cls;
            cap_bud_q      <= rd_bud;
            cap_used_q     <= rd_used;
            cap_peak_q     <= rd_peak;
            valid_q[hit_q] <= 1'b0;
            sum_q          <= sum_q - SumW'(rd_used);
            for (int c = 0; c < 4; c++) cnt_q[c] <= '0;
            code_q         <= CODE_EVICTED;
            sel_q          <= SEL_CAPT;
            state_q        <= S_CNT;
          end
        end

        // Count members of each class.
        S_CNT: begin
          for (int c = 0; c < 4; c++) begin
            if (rd_valid && (rd_cls == 2'(c))) cnt_q[c] <= cnt_q[c] + 1'b1;
          end
          if (last_ptr) begin
            ci_q    <= '0;
            state_q <= S_MULLO;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end

        // Low half of available times fraction, or an empty class.
        S_MULLO: begin
          if (cnt_q[ci_q] == '0) begin
            bud_q[ci_q] <= '0;
            if (ci_q == 2'd3) begin
              if (op_q == OP_PRESSURE) begin
                ptr_q  <= '0;
                sent_q <= '0;
                if (mask_q == '0) begin
                  zid_q   <= '0;
                  code_q  <= CODE_OK;
                  sel_q   <= SEL_ZERO;
                  state_q <= S_SEND;
                end else begin
                  sel_q   <= SEL_ENTRY;
                  state_q <= S_EFIND;
                end
              end else begin
                state_q <= S_SEND;
              end
            end else begin
              ci_q <= ci_q + 1'b1;
            end
          end else begin
            acc_q   <= mul_p;
            state_q <= S_MULHI;
          end
        end

        // High half; keep the product scaled down by 2^16 as the dividend.
        S_MULHI: begin
          quo_q   <= mul_sum[64:16];
          rem_q   <= '0;
          bit_q   <= '0;
          state_q <= S_DIV;
        end

        // One quotient bit per cycle.
        S_DIV: begin
          rem_q <= div_ge ? rem_sub[CntW-1:0] : rem_s[CntW-1:0];
          quo_q <= {quo_q[QuoW-2:0], div_ge};
          bit_q <= bit_q + 1'b1;
          if (bit_q == 6'(QuoW - 1)) state_q <= S_CLAMP;
        end

        // Clamp, store, and move to the next class or the result.
        S_CLAMP: begin
          bud_q[ci_q] <= clamp_b[BytesW-1:0];
          if (ci_q == 2'd3) begin
            if (op_q == OP_PRESSURE) begin
              ptr_q  <= '0;
              sent_q <= '0;
              if (mask_q == '0) begin
                zid_q   <= '0;
                code_q  <= CODE_OK;
                sel_q   <= SEL_ZERO;
                state_q <= S_SEND;
              end else begin
                sel_q   <= SEL_ENTRY;
                state_q <= S_EFIND;
              end
            end else begin
              state_q <= S_SEND;
            end
          end else begin
            ci_q    <= ci_q + 1'b1;
            state_q <= S_MULLO;
          end
        end

        // Walk to the next requested slot.
        S_EFIND: begin
          if (mask_q[ptr_q]) state_q <= S_SEND;
          else ptr_q <= ptr_q + 1'b1;
        end

        // Load one result once the output register is free.
        S_SEND: begin
          if (out_free) begin
            out_valid_o        <= 1'b1;
            active_count_o     <= cnt_q[0][4:0];
            media_count_o      <= cnt_q[1][4:0];
            background_count_o <= cnt_q[2][4:0];
            suspended_count_o  <= cnt_q[3][4:0];
            total_used_o       <= sum_q;
            last_o             <= send_last;
            case (sel_q)
              SEL_ENTRY: begin
                client_out_o <= rd_id;
                code_o       <= pres_send ? pres_code : code_q;
                class_out_o  <= rd_cls;
                budget_out_o <= rd_bud;
                used_out_o   <= rd_used;
                peak_out_o   <= rd_peak;
              end
              SEL_CAPT: begin
                client_out_o <= cap_id_q;
                code_o       <= code_q;
                class_out_o  <= cap_cls_q;
                budget_out_o <= cap_bud_q;
                used_out_o   <= cap_used_q;
                peak_out_o   <= cap_peak_q;
              end
              default: begin
                client_out_o <= zid_q;
                code_o       <= code_q;
                class_out_o  <= '0;
                budget_out_o <= '0;
                used_out_o   <= '0;
                peak_out_o   <= '0;
              end
            endcase
            if (send_last) begin
              state_q <= S_IDLE;
            end else begin
              mask_q[ptr_q] <= 1'b0;
              sent_q        <= sent_q + 1'b1;
              ptr_q         <= ptr_q + 1'b1;
              state_q       <= S_EFIND;
            end
          end else if (out_valid_o && out_ready_i) begin
            out_valid_o <= 1'b0;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Class counts agree with the occupied slots whenever the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |->
      ($countones(valid_q) == (int'(cnt_q[0]) + int'(cnt_q[1]) + int'(cnt_q[2]) +
                               int'(cnt_q[3]))))
    else $error("class counts disagree with occupied slots");

  // A pressure walk never sends more than the result limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(sent_q) < MaxResults))
    else $error("pressure walk overran the result limit");

  // A result without the last mark is always followed by more work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |-> (state_q != S_IDLE))
    else $error("sequencer idle before the final result");
`endif

endmodule
`default_nettype wire

### test/tb.sv
// Self-checking testbench for the client memory budget table.
`default_nettype none
module tb import cmb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // One result transaction as seen on the output channel.
  typedef struct {
    logic [IdW-1:0]    client;
    logic [2:0]        code;
    logic [1:0]        cls;
    logic [BytesW-1:0] budget;
    logic [BytesW-1:0] used;
    logic [BytesW-1:0] peak;
    logic [4:0]        cnt [4];
    logic [SumW-1:0]   total;
    logic              last;
  } budget_result_t;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 300;
  localparam int NumIds        = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] op_i = OP_QUERY;
  logic [IdW-1:0] client_id_i = '0;
  logic [1:0] class_in_i = '0;
  logic [BytesW-1:0] used_in_i = '0;
  logic [7:0] pressure_level_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [IdW-1:0] client_out_o;
  logic [2:0] code_o;
  logic [1:0] class_out_o;
  logic [BytesW-1:0] budget_out_o, used_out_o, peak_out_o;
  logic [4:0] active_count_o, media_count_o, background_count_o, suspended_count_o;
  logic [SumW-1:0] total_used_o;
  logic last_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic pready;

  class_memory_budget_table DUT (.*);

  // Clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of registers and table used for prediction.
  logic [47:0] avail_bytes;
  logic [16:0] class_frac [4];
  logic [17:0] min_mib, max_mib;
  logic        slot_valid [MaxTabs];
  logic [47:0] slot_id [MaxTabs];
  logic [1:0]  slot_cls [MaxTabs];
  logic [47:0] slot_used [MaxTabs];
  logic [47:0] slot_peak [MaxTabs];
  int          class_members [4];
  logic [47:0] class_budget [4];
  logic [51:0] usage_sum;

  budget_result_t pending_results [$];
  logic [IdW-1:0] id_pool [NumIds];
  int  mismatches = 0;
  bit  sender_quiet = 1'b0;
  bit  receiver_quiet = 1'b0;

  // Recompute per-class budgets from the current membership.
  function automatic void recompute_budgets();
    int n [4];
    logic [64:0] prod;
    logic [48:0] quo;
    logic [64:0] lo, hi, b;
    logic [16:0] f;
    n = '{0, 0, 0, 0};
    for (int s = 0; s < MaxTabs; s++)
      if (slot_valid[s]) n[slot_cls[s]]++;
    for (int c = 0; c < 4; c++) begin
      class_members[c] = n[c];
      if (n[c] == 0) begin
        class_budget[c] = '0;
      end else begin
        f = (class_frac[c] > FracOne) ? FracOne : class_frac[c];
        prod = 65'(avail_bytes) * 65'(f);
        quo = prod[64:16];
        b = 65'(quo / 49'(n[c]));
        lo = 65'(min_mib) << 20;
        hi = 65'(max_mib) << 20;
        if (b < lo) b = lo;
        if (b > hi) b = hi;
        class_budget[c] = b[47:0];
      end
    end
  endfunction

  function automatic budget_result_t make_result(logic [47:0] id, code_e code, logic [1:0] cls,
                                                 logic [47:0] budget, logic [47:0] used,
                                                 logic [47:0] peak);
    budget_result_t r;
    r.client = id;
    r.code = code;
    r.cls = cls;
    r.budget = budget;
    r.used = used;
    r.peak = peak;
    for (int c = 0; c < 4; c++) r.cnt[c] = 5'(class_members[c]);
    r.total = usage_sum;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic budget_result_t slot_result(int s, code_e code);
    return make_result(slot_id[s], code, slot_cls[s], class_budget[slot_cls[s]],
                       slot_used[s], slot_peak[s]);
  endfunction

  // Apply one operation to the shadow table and queue the results it causes.
  function automatic void predict_table_op(logic [2:0] op, logic [47:0] id, logic [1:0] cls,
                                           logic [47:0] used, logic [7:0] lvl);
    budget_result_t res [$];
    int hit;
    int best;
    logic [1:0] c;
    logic [47:0] b, bu;
    hit = -1;
    best = -1;
    bu = '0;
    c = '0;
    for (int s = 0; s < MaxTabs; s++)
      if (hit < 0 && slot_valid[s] && slot_id[s] == id) hit = s;
    if (op == OP_NONE) return;
    if (op inside {OP_UNREGISTER, OP_SETCLASS, OP_REPORT, OP_QUERY} && hit < 0) begin
      res.push_back(make_result(id, CODE_NOTFOUND, '0, '0, '0, '0));
    end else begin
      case (op)
        OP_REGISTER: begin
          if (hit < 0) begin
            for (int s = 0; s < MaxTabs; s++)
              if (hit < 0 && !slot_valid[s]) hit = s;
            if (hit >= 0) begin
              slot_valid[hit] = 1'b1;
              slot_id[hit] = id;
            end
          end else begin
            usage_sum = usage_sum - 52'(slot_used[hit]);
          end
          if (hit < 0) begin
            res.push_back(make_result(id, CODE_FULL, '0, '0, '0, '0));
          end else begin
            slot_cls[hit] = cls;
            slot_used[hit] = '0;
            slot_peak[hit] = '0;
            recompute_budgets();
            res.push_back(slot_result(hit, CODE_OK));
          end
        end
        OP_UNREGISTER: begin
          c = slot_cls[hit];
          b = class_budget[c];
          slot_valid[hit] = 1'b0;
          usage_sum = usage_sum - 52'(slot_used[hit]);
          recompute_budgets();
          res.push_back(make_result(id, CODE_OK, c, b, slot_used[hit], slot_peak[hit]));
        end
        OP_SETCLASS: begin
          slot_cls[hit] = cls;
          recompute_budgets();
          res.push_back(slot_result(hit, CODE_OK));
        end
        OP_REPORT: begin
          usage_sum = usage_sum - 52'(slot_used[hit]) + 52'(used);
          slot_used[hit] = used;
          if (used > slot_peak[hit]) slot_peak[hit] = used;
          res.push_back(slot_result(hit, CODE_OK));
        end
        OP_QUERY: res.push_back(slot_result(hit, CODE_OK));
        OP_PRESSURE: begin
          int req_slot [$];
          code_e req_code [$];
          for (int s = 0; s < MaxTabs; s++) begin
            if (slot_valid[s] && req_slot.size() < MaxResults) begin
              if (lvl >= LvlCritical) begin
                if (slot_cls[s] == CLS_BACKGROUND) begin
                  req_slot.push_back(s);
                  req_code.push_back(CODE_SUSPEND);
                end else if (slot_cls[s] == CLS_ACTIVE) begin
                  req_slot.push_back(s);
                  req_code.push_back(CODE_GC);
                end
              end else if (lvl >= LvlModerate) begin
                if (slot_used[s] > class_budget[slot_cls[s]]) begin
                  req_slot.push_back(s);
                  req_code.push_back(CODE_GC);
                end
              end
            end
          end
          recompute_budgets();
          if (req_slot.size() == 0) res.push_back(make_result('0, CODE_OK, '0, '0, '0, '0));
          foreach (req_slot[i]) res.push_back(slot_result(req_slot[i], req_code[i]));
        end
        default: begin
          // Victim: highest class number except media, then larger usage, then lower slot.
          for (int s = 0; s < MaxTabs; s++) begin
            if (slot_valid[s] && slot_cls[s] != CLS_MEDIA) begin
              if (best < 0 || slot_cls[s] > c || (slot_cls[s] == c && slot_used[s] > bu)) begin
                best = s;
                c = slot_cls[s];
                bu = slot_used[s];
              end
            end
          end
          if (best < 0) begin
            res.push_back(make_result('0, CODE_NOVICTIM, '0, '0, '0, '0));
          end else begin
            b = class_budget[c];
            slot_valid[best] = 1'b0;
            usage_sum = usage_sum - 52'(slot_used[best]);
            recompute_budgets();
            res.push_back(make_result(slot_id[best], CODE_EVICTED, c, b, slot_used[best],
                                      slot_peak[best]));
          end
        end
      endcase
    end
    res[res.size() - 1].last = 1'b1;
    foreach (res[i]) pending_results.push_back(res[i]);
  endfunction

  // Random gap length: mostly none or short, a few long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Send one operation and hold it until the transaction is accepted.
  task automatic send_op(logic [2:0] op, logic [47:0] id, logic [1:0] cls,
                         logic [47:0] used, logic [7:0] lvl);
    int gap;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    op_i = op;
    client_id_i = id;
    class_in_i = cls;
    used_in_i = used;
    pressure_level_i = lvl;
    do @(posedge clk_i); while (!in_ready_o);
    predict_table_op(op, id, cls, used, lvl);
    gap = sender_quiet ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic release_valid();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Let the block finish all work before touching registers.
  task automatic wait_idle();
    release_valid();
    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = PaddrW'(8 * idx);
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      RegAvail:     avail_bytes = value[47:0];
      RegFracAct:   class_frac[CLS_ACTIVE] = value[16:0];
      RegFracMedia: class_frac[CLS_MEDIA] = value[16:0];
      RegFracBg:    class_frac[CLS_BACKGROUND] = value[16:0];
      RegFracSusp:  class_frac[CLS_SUSPENDED] = value[16:0];
      RegMinMib:    min_mib = value[17:0];
      default:      max_mib = value[17:0];
    endcase
  endtask

  task automatic write_all_regs(logic [47:0] av, logic [16:0] fa, logic [16:0] fm,
                                logic [16:0] fb, logic [16:0] fs, logic [17:0] mn,
                                logic [17:0] mx);
    write_reg(RegAvail, 64'(av));
    write_reg(RegFracAct, 64'(fa));
    write_reg(RegFracMedia, 64'(fm));
    write_reg(RegFracBg, 64'(fb));
    write_reg(RegFracSusp, 64'(fs));
    write_reg(RegMinMib, 64'(mn));
    write_reg(RegMaxMib, 64'(mx));
  endtask

  function automatic logic [47:0] rand_id();
    if ($urandom_range(0, 9) == 0) return {16'($urandom), 32'($urandom)};
    return id_pool[$urandom_range(0, NumIds - 1)];
  endfunction

  function automatic logic [47:0] rand_used();
    case ($urandom_range(0, 3))
      0: return 48'($urandom_range(0, 1 << 20));
      1: return 48'($urandom) << $urandom_range(0, 8);
      2: return {16'($urandom), 32'($urandom)};
      default: return 48'($urandom_range(1, 1 << 30));
    endcase
  endfunction

  // One random operation weighted toward well-formed use of known clients.
  task automatic send_random_op();
    int r;
    logic [2:0] op;
    r = $urandom_range(0, 99);
    if (r < 25) op = OP_REGISTER;
    else if (r < 45) op = OP_REPORT;
    else if (r < 55) op = OP_QUERY;
    else if (r < 65) op = OP_SETCLASS;
    else if (r < 76) op = OP_UNREGISTER;
    else if (r < 87) op = OP_PRESSURE;
    else if (r < 97) op = OP_EVICT;
    else op = OP_NONE;
    send_op(op, rand_id(), 2'($urandom), rand_used(),
            ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)));
  endtask

  // Directed extremes and special cases.
  task automatic test_directed();
    send_op(OP_EVICT, '0, '0, '0, 8'd0);
    send_op(OP_QUERY, '1, '0, '0, 8'd0);
    send_op(OP_REGISTER, '1, CLS_MEDIA, '0, 8'd0);
    send_op(OP_EVICT, '0, '0, '0, 8'd0);
    send_op(OP_REGISTER, '0, CLS_ACTIVE, '0, 8'd0);
    send_op(OP_REGISTER, 48'h5555_AAAA_5555, CLS_BACKGROUND, '0, 8'd0);
    send_op(OP_REGISTER, 48'hAAAA_5555_AAAA, CLS_SUSPENDED, '0, 8'd0);
    send_op(OP_REPORT, '0, '0, '1, 8'd0);
    send_op(OP_REPORT, '0, '0, 48'd1000, 8'd0);
    send_op(OP_REPORT, '1, '0, 48'h4000_0000, 8'd0);
    send_op(OP_PRESSURE, '0, '0, '0, 8'd2);
    send_op(OP_PRESSURE, '0, '0, '0, 8'd3);
    send_op(OP_PRESSURE, '0, '0, '0, 8'd255);
    send_op(OP_PRESSURE, '0, '0, '0, 8'd1);
    send_op(OP_SETCLASS, '1, CLS_SUSPENDED, '0, 8'd0);
    send_op(OP_NONE, '1, '1, '1, 8'hFF);
    send_op(OP_REGISTER, '0, CLS_MEDIA, '0, 8'd0);
    send_op(OP_EVICT, '0, '0, '0, 8'd0);
    send_op(OP_UNREGISTER, '1, '0, '0, 8'd0);
    send_op(OP_UNREGISTER, '1, '0, '0, 8'd0);
    send_op(OP_SETCLASS, 48'h1, CLS_ACTIVE, '0, 8'd0);
    send_op(OP_REPORT, 48'h2, '0, '0, 8'd0);
    wait_idle();
  endtask

  // Fill past capacity so the table-full case and a full pressure burst occur.
  task automatic test_table_full();
    for (int i = 0; i < MaxTabs + 2; i++)
      send_op(OP_REGISTER, 48'h1000 + 48'(i), (i % 2) ? CLS_ACTIVE : CLS_BACKGROUND, '0, 8'd0);
    send_op(OP_PRESSURE, '0, '0, '0, 8'd3);
    for (int i = 0; i < MaxTabs; i++) send_op(OP_EVICT, '0, '0, '0, 8'd0);
    wait_idle();
  endtask

  // Register settings from one extreme to the other, each followed by traffic.
  task automatic test_register_settings();
    write_all_regs('1, 17'd65536, 17'h1FFFF, 17'd0, 17'd1, 18'd0, 18'h3FFFF);
    repeat (25) send_random_op();
    wait_idle();
    write_all_regs('0, 17'd0, 17'd0, 17'd0, 17'd0, 18'h3FFFF, 18'd0);
    repeat (20) send_random_op();
    wait_idle();
    write_all_regs(48'd8 << 30, 17'd20000, 17'd30000, 17'd10000, 17'd5000, 18'd1, 18'd100);
    repeat (25) send_random_op();
    wait_idle();
  endtask

  // Main random traffic, with a back-to-back stretch and a pause for the drain.
  task automatic test_random_traffic();
    repeat (100) send_random_op();
    release_valid();
    wait (pending_results.size() == 0);
    sender_quiet = 1'b1;
    receiver_quiet = 1'b1;
    repeat (40) send_random_op();
    sender_quiet = 1'b0;
    receiver_quiet = 1'b0;
    wait_idle();
    write_all_regs(48'd3758096384, 17'd39322, 17'd16384, 17'd6554, 17'd3277, 18'd32, 18'd512);
    repeat (90) send_random_op();
    wait_idle();
  endtask

  // Receiver stalls.
  always @(negedge clk_i) begin
    int g;
    if (receiver_quiet) begin
      out_ready_i <= 1'b1;
    end else begin
      g = gap_len();
      out_ready_i <= (g == 0);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    budget_result_t e;
    logic [4:0] got_cnt [4];
    bit bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: client %h code %0d", client_out_o, code_o);
      end else begin
        e = pending_results.pop_front();
        got_cnt = '{active_count_o, media_count_o, background_count_o, suspended_count_o};
        bad = (e.client !== client_out_o) || (e.code !== code_o) || (e.cls !== class_out_o)
           || (e.budget !== budget_out_o) || (e.used !== used_out_o) || (e.peak !== peak_out_o)
           || (e.total !== total_used_o) || (e.last !== last_o);
        for (int c = 0; c < 4; c++) if (e.cnt[c] !== got_cnt[c]) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch expected: id %h code %0d cls %0d budget %h used %h peak %h",
                     e.client, e.code, e.cls, e.budget, e.used, e.peak);
            $display("  counts %0d %0d %0d %0d total %h last %0d",
                     e.cnt[0], e.cnt[1], e.cnt[2], e.cnt[3], e.total, e.last);
            $display("Mismatch actual:   id %h code %0d cls %0d budget %h used %h peak %h",
                     client_out_o, code_o, class_out_o, budget_out_o, used_out_o, peak_out_o);
            $display("  counts %0d %0d %0d %0d total %h last %0d",
                     active_count_o, media_count_o, background_count_o, suspended_count_o,
                     total_used_o, last_o);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    int idle_cycles;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    avail_bytes = 48'd3758096384;
    class_frac = '{17'd39322, 17'd16384, 17'd6554, 17'd3277};
    min_mib = 18'd32;
    max_mib = 18'd512;
    for (int s = 0; s < MaxTabs; s++) begin
      slot_valid[s] = 1'b0;
      slot_id[s] = '0;
      slot_cls[s] = '0;
      slot_used[s] = '0;
      slot_peak[s] = '0;
    end
    class_members = '{0, 0, 0, 0};
    class_budget = '{48'd0, 48'd0, 48'd0, 48'd0};
    usage_sum = '0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < NumIds; i++) id_pool[i] = {16'($urandom), 32'($urandom)};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_table_full();
    test_register_settings();
    test_random_traffic();

    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
